### src/bpba_pkg.sv
package bpba_pkg;

  localparam int BIN_W   = 9;
  localparam int CHAN_W  = 3;
  localparam int POWER_W = 32;
  localparam int SUM_W   = 40;
  localparam int BAND_W  = 2;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W   = 4;
  localparam int NUM_BAND_REGS = 4;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND0         = 3'd0,
    REG_BAND1         = 3'd1,
    REG_BAND2         = 3'd2,
    REG_BAND3         = 3'd3,
    REG_CHANNEL_COUNT = 3'd4
  } cfg_reg_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [BIN_W-1:0] lo;
    logic [BIN_W-1:0] hi;
  } band_range_t;

  // accumulator to emitter handoff at block end
  typedef struct packed {
    logic             load;
    logic             seen;
    logic [CNT_W-1:0] nch;
  } handoff_t;

endpackage

### src/band_power_bin_accumulator.sv
// Band power accumulator: sums spectrum bin powers per band and channel.
// Input channel (in_valid/in_ready): one item per bin of one channel, with
//   bin, channel, bin_power (Q16.16), has_value and block_end. An item with
//   has_value low and block_end high is a bare end marker.
// Config channel (cfg_valid/cfg_ready): index 0..3 band bin ranges (low bin in
//   bits 8:0, high bin in bits 17:9), index 4 channel count. Always ready;
//   write only while the block is idle.
// Output channel (out_valid/out_ready): at block end, one item per band and
//   channel in use, band-major, last set on the final one; Q24.16 sums
//   saturate at 40 bits. A block with no value gives one empty-status item.
// Throughput: one input item per cycle while no block end is stalled; the
//   add path (one 40-bit adder per band behind an 8:1 read mux) sets this.
//   The block-end item passes the input register, then loads the drain
//   buffer, then the first result is registered at the output.
// The block's sums are copied to a drain buffer at block end, so bins of the
// next block flow in during the drain. A second block end stalls the input
// until the previous drain is done. When out_ready is low the output holds.
// Reset (rst, synchronous) clears all sums, sets band ranges to empty and
// the channel count to 8.
module band_power_bin_accumulator #(
  parameter int NUM_BANDS    = 4,
  parameter int MAX_CHANNELS = 8,
  parameter int FFT_SIZE     = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpba_pkg::BIN_W-1:0]     bin,
  input  logic [bpba_pkg::CHAN_W-1:0]    channel,
  input  logic [bpba_pkg::POWER_W-1:0]   bin_power,
  input  logic                          has_value,
  input  logic                          block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpba_pkg::BAND_W-1:0]    band,
  output logic [bpba_pkg::CHAN_W-1:0]    out_channel,
  output logic [bpba_pkg::SUM_W-1:0]     band_power,
  output logic                          status,
  output logic                          last
);
  import bpba_pkg::*;

  band_range_t      bands [NUM_BAND_REGS];
  logic [CNT_W-1:0] nch;
  logic             emit_busy;
  handoff_t         handoff;
  logic [SUM_W-1:0] snap [NUM_BANDS][MAX_CHANNELS];

  // config registers, clamped ranges and effective channel count
  bpba_cfg #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .FFT_SIZE     (FFT_SIZE)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bands     (bands),
    .nch       (nch)
  );

  // input register plus live band x channel sums
  bpba_accum #(
    .NUM_BANDS    (NUM_BANDS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .bin       (bin),
    .channel   (channel),
    .bin_power (bin_power),
    .has_value (has_value),
    .block_end (block_end),
    .bands     (bands),
    .nch       (nch),
    .emit_busy (emit_busy),
    .handoff   (handoff),
    .snap      (snap)
  );

  // drain buffer and output register
  bpba_emit #(
    .NUM_BANDS    (NUM_BANDS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .handoff     (handoff),
    .snap        (snap),
    .busy        (emit_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .band        (band),
    .out_channel (out_channel),
    .band_power  (band_power),
    .status      (status),
    .last        (last)
  );

endmodule

### src/bpba_cfg.sv
module bpba_cfg #(
  parameter int MAX_CHANNELS = 8,
  parameter int FFT_SIZE     = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpba_pkg::CFG_W-1:0]     cfg_data,
  output bpba_pkg::band_range_t          bands [bpba_pkg::NUM_BAND_REGS],
  output logic [bpba_pkg::CNT_W-1:0]     nch
);
  import bpba_pkg::*;

  localparam int TOP = FFT_SIZE / 2 - 1;
  localparam logic [BIN_W-1:0] BIN_TOP = BIN_W'(TOP);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHANNELS);

  logic [CFG_W-1:0] band_regs [NUM_BAND_REGS];
  logic [CNT_W-1:0] channel_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BAND_REGS; i++) begin
        band_regs[i] <= CFG_W'(1);
      end
      channel_count <= CNT_W'(8);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BAND0:         band_regs[0] <= cfg_data;
        REG_BAND1:         band_regs[1] <= cfg_data;
        REG_BAND2:         band_regs[2] <= cfg_data;
        REG_BAND3:         band_regs[3] <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp high edge to the last usable bin
  always_comb begin
    for (int i = 0; i < NUM_BAND_REGS; i++) begin
      bands[i].lo = band_regs[i][BIN_W-1:0];
      bands[i].hi = (band_regs[i][2*BIN_W-1:BIN_W] > BIN_TOP) ? BIN_TOP
                                                             : band_regs[i][2*BIN_W-1:BIN_W];
    end
  end

  always_comb begin
    if (channel_count == '0) begin
      nch = CNT_W'(1);
    end else if (channel_count > CNT_MAX) begin
      nch = CNT_MAX;
    end else begin
      nch = channel_count;
    end
  end

endmodule

### src/bpba_accum.sv
module bpba_accum #(
  parameter int NUM_BANDS    = 4,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bpba_pkg::BIN_W-1:0]   bin,
  input  logic [bpba_pkg::CHAN_W-1:0]  channel,
  input  logic [bpba_pkg::POWER_W-1:0] bin_power,
  input  logic                         has_value,
  input  logic                         block_end,
  input  bpba_pkg::band_range_t        bands [bpba_pkg::NUM_BAND_REGS],
  input  logic [bpba_pkg::CNT_W-1:0]   nch,
  input  logic                         emit_busy,
  output bpba_pkg::handoff_t           handoff,
  output logic [bpba_pkg::SUM_W-1:0]   snap [NUM_BANDS][MAX_CHANNELS]
);
  import bpba_pkg::*;

  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic               s_valid;
  logic [BIN_W-1:0]   s_bin;
  logic [CHAN_W-1:0]  s_ch;
  logic [POWER_W-1:0] s_power;
  logic               s_has;
  logic               s_end;

  logic [SUM_W-1:0] sums      [NUM_BANDS][MAX_CHANNELS];
  logic [SUM_W-1:0] sums_next [NUM_BANDS][MAX_CHANNELS];
  logic [SUM_W:0]   acc       [NUM_BANDS];
  logic [NUM_BANDS-1:0] hit;
  logic             seen;
  logic             seen_next;
  logic             use_value;
  logic             advance;
  logic [CH_IDX_W-1:0] ch_idx;

  // a block end waits until the previous block has drained
  assign advance   = s_valid && (!s_end || !emit_busy);
  assign in_ready  = !s_valid || advance;
  assign ch_idx    = s_ch[CH_IDX_W-1:0];
  assign use_value = s_has && (CNT_W'(s_ch) < nch);
  assign seen_next = seen || use_value;

  always_comb begin
    sums_next = sums;
    for (int b = 0; b < NUM_BANDS; b++) begin
      hit[b] = use_value && (s_bin >= bands[b].lo) && (s_bin <= bands[b].hi);
      acc[b] = {1'b0, sums[b][ch_idx]} + (SUM_W+1)'(s_power);
      if (hit[b]) begin
        sums_next[b][ch_idx] = acc[b][SUM_W] ? SUM_MAX : acc[b][SUM_W-1:0];
      end
    end
  end

  assign snap         = sums_next;
  assign handoff.load = advance && s_end;
  assign handoff.seen = seen_next;
  assign handoff.nch  = nch;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_bin   <= bin;
      s_ch    <= channel;
      s_power <= bin_power;
      s_has   <= has_value;
      s_end   <= block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          sums[b][c] <= '0;
        end
      end
    end else if (advance) begin
      if (s_end) begin
        seen <= 1'b0;
        for (int b = 0; b < NUM_BANDS; b++) begin
          for (int c = 0; c < MAX_CHANNELS; c++) begin
            sums[b][c] <= '0;
          end
        end
      end else begin
        seen <= seen_next;
        sums <= sums_next;
      end
    end
  end

endmodule

### src/bpba_emit.sv
module bpba_emit #(
  parameter int NUM_BANDS    = 4,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bpba_pkg::handoff_t           handoff,
  input  logic [bpba_pkg::SUM_W-1:0]   snap [NUM_BANDS][MAX_CHANNELS],
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpba_pkg::BAND_W-1:0]  band,
  output logic [bpba_pkg::CHAN_W-1:0]  out_channel,
  output logic [bpba_pkg::SUM_W-1:0]   band_power,
  output logic                         status,
  output logic                         last
);
  import bpba_pkg::*;

  localparam int CH_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int BAND_IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [BAND_IDX_W-1:0] LAST_BAND = BAND_IDX_W'(NUM_BANDS - 1);

  logic [SUM_W-1:0]      shadow [NUM_BANDS][MAX_CHANNELS];
  logic                  e_empty;
  logic [BAND_IDX_W-1:0] e_band;
  logic [CH_IDX_W-1:0]   e_ch;
  logic [CNT_W-1:0]      e_nch;
  logic                  take;
  logic                  ch_wrap;
  logic                  final_entry;

  assign take        = busy && (!out_valid || out_ready);
  assign ch_wrap     = (CNT_W'(e_ch) + CNT_W'(1)) == e_nch;
  assign final_entry = ch_wrap && (e_band == LAST_BAND);

  always_ff @(posedge clk) begin
    if (handoff.load) begin
      shadow <= snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (handoff.load) begin
      busy <= 1'b1;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (take) begin
      out_valid <= 1'b1;
      if (e_empty || final_entry) begin
        busy <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff.load) begin
      e_empty <= !handoff.seen;
      e_band  <= '0;
      e_ch    <= '0;
      e_nch   <= handoff.nch;
    end else if (take) begin
      if (e_empty) begin
        band        <= '0;
        out_channel <= '0;
        band_power  <= '0;
        status      <= STATUS_EMPTY;
        last        <= 1'b1;
      end else begin
        band        <= BAND_W'(e_band);
        out_channel <= CHAN_W'(e_ch);
        band_power  <= shadow[e_band][e_ch];
        status      <= STATUS_OK;
        last        <= final_entry;
        if (ch_wrap) begin
          e_ch   <= '0;
          e_band <= e_band + BAND_IDX_W'(1);
        end else begin
          e_ch <= e_ch + CH_IDX_W'(1);
        end
      end
    end
  end

endmodule

### src/bpba_checker.sv
module bpba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bpba_pkg::BAND_W-1:0]  band,
  input logic [bpba_pkg::CHAN_W-1:0]  out_channel,
  input logic [bpba_pkg::SUM_W-1:0]   band_power,
  input logic                         status,
  input logic                         last
);
  import bpba_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(band_power) && $stable(last)
      && $stable(band) && $stable(out_channel))
    else $error("result changed while stalled");

  // empty-block result has a fixed form and closes the block
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_EMPTY) |->
      last && (band_power == '0) && (band == '0) && (out_channel == '0))
    else $error("malformed empty-block result");

  // a result following a non-final result of the same block never restarts band 0 channel 0
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last ##1 out_valid |->
      !((band == '0) && (out_channel == '0)))
    else $error("block restarted without a last result");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind band_power_bin_accumulator bpba_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .band        (band),
  .out_channel (out_channel),
  .band_power  (band_power),
  .status      (status),
  .last        (last)
);
